/* rtl/core/rsfh_pkg.sv */
// Shared widths, payload types and divider control for the ray/segment first-hit block.
`default_nettype none

package rsfh_pkg;

   // Field widths: coordinates Q16.16, directions Q1.14
   localparam int COORD_WIDTH = 32;
   localparam int DIR_WIDTH   = 16;

   // Shared multiplier operands hold any difference of two coordinates
   localparam int MUL_WIDTH  = ((COORD_WIDTH > DIR_WIDTH) ? COORD_WIDTH : DIR_WIDTH) + 1;
   localparam int PROD_WIDTH = 2 * MUL_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + 1;

   // Result formats
   localparam int DIST_BITS  = 31;
   localparam int DIST_SHIFT = DIR_WIDTH - 2;
   localparam int POS_FRAC   = 16;
   localparam int POS_BITS   = POS_FRAC + 1;

   // Divider: one quotient bit per cycle, top bit of a distance quotient flags saturation
   localparam int QUOT_WIDTH = DIST_BITS + 1;
   localparam int WIDE_WIDTH = ACC_WIDTH + QUOT_WIDTH;
   localparam int CNT_WIDTH  = $clog2(QUOT_WIDTH);

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] ray_origin_x;
      logic signed [COORD_WIDTH-1:0] ray_origin_y;
      logic signed [DIR_WIDTH-1:0]   ray_dir_x;
      logic signed [DIR_WIDTH-1:0]   ray_dir_y;
      logic signed [COORD_WIDTH-1:0] seg_start_x;
      logic signed [COORD_WIDTH-1:0] seg_start_y;
      logic signed [COORD_WIDTH-1:0] seg_end_x;
      logic signed [COORD_WIDTH-1:0] seg_end_y;
      logic signed [DIR_WIDTH-1:0]   normal_x;
      logic signed [DIR_WIDTH-1:0]   normal_y;
      logic [1:0]                    face_tag;
      logic                          last_segment;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [DIST_BITS-1:0] distance;
      logic [POS_BITS-1:0]  wall_position;
      logic [1:0]           hit_face;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [CNT_WIDTH-1:0] last_bit;
   } div_ctl_type;

endpackage

`default_nettype wire

/* rtl/core/rsfh_div.sv */
// Restoring divider producing one quotient bit per cycle from a pre-shifted divisor.
`default_nettype none

module rsfh_div (
   input  wire                                  clock,
   input  wire                                  reset,
   input  rsfh_pkg::div_ctl_type                ctl,
   input  wire [rsfh_pkg::WIDE_WIDTH-1:0]       dividend,
   input  wire [rsfh_pkg::WIDE_WIDTH-1:0]       divisor,
   output logic                                 done,
   output logic [rsfh_pkg::QUOT_WIDTH-1:0]      quot
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [rsfh_pkg::CNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic [rsfh_pkg::WIDE_WIDTH-1:0]    rem_ff, rem_in;
   logic [rsfh_pkg::WIDE_WIDTH-1:0]    dsh_ff, dsh_in;
   logic [rsfh_pkg::QUOT_WIDTH-1:0]    q_ff, q_in;
   logic                               ge;

   // Compare, subtract and shift the divisor down one place per cycle
   always_comb begin
      ge      = (rem_ff >= dsh_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = ctl.last_bit;
         rem_in  = dividend;
         dsh_in  = divisor;
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in = ge ? (rem_ff - dsh_ff) : rem_ff;
         dsh_in = dsh_ff >> 1;
         q_in   = {q_ff[rsfh_pkg::QUOT_WIDTH-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

/* rtl/core/ray_segment_first_hit.sv */
// Top level: first ray/wall-segment hit over a run of segment requests.
//
// Requests enter on req_valid/req_stall with a req_type payload: one ray and
// one wall segment each. The run's result leaves on rsp_valid/rsp_stall with
// a rsp_type payload, only for the request flagged last_segment.
// One request is in work at a time; req_stall stays high while it is busy.
// A request that is tested passes through capture, prep, 9 multiply steps
// and a check, plus a distance and a position division when it hits.
// Requests arriving after a hit in the same run are consumed without a
// test. The shared multiplier sequences eight products; the bit-serial
// divider sets the hit latency.
// A last request enters a done state to present its result, held until
// rsp_stall is low. While the result waits, req_stall stays high.
// Reset clears the held hit and returns the sequencer to idle.
`default_nettype none

module ray_segment_first_hit (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  rsfh_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output rsfh_pkg::rsp_type  rsp_data
);

   localparam int MW = rsfh_pkg::MUL_WIDTH;
   localparam int AW = rsfh_pkg::ACC_WIDTH;
   localparam int WW = rsfh_pkg::WIDE_WIDTH;
   localparam int STEP_WIDTH = 4;
   localparam int LAST_STEP  = 8;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_PREP  = 7'b0000010,
      S_MUL   = 7'b0000100,
      S_CHECK = 7'b0001000,
      S_DIST  = 7'b0010000,
      S_POS   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type                        state_ff, state_in;
   rsfh_pkg::req_type                item_ff, item_in;
   logic [STEP_WIDTH-1:0]            step_ff, step_in;
   logic signed [MW-1:0]             d2x_ff, d2x_in, d2y_ff, d2y_in;
   logic signed [MW-1:0]             wx_ff, wx_in, wy_ff, wy_in;
   logic signed [MW-1:0]             vx_ff, vx_in, vy_ff, vy_in;
   logic signed [MW-1:0]             op_a, op_b;
   logic signed [rsfh_pkg::PROD_WIDTH-1:0] prod_ff, prod_in;
   logic signed [AW-1:0]             prod_ext;
   logic signed [AW-1:0]             dot_ff, dot_in, den_ff, den_in;
   logic signed [AW-1:0]             crs_ff, crs_in, num_ff, num_in;
   logic [AW-1:0]                    aden, acrs, anum;
   logic                             dneg, behind, short_of, beyond, is_hit;
   logic                             found_ff, found_in;
   logic [rsfh_pkg::DIST_BITS-1:0]   dist_ff, dist_in;
   logic [rsfh_pkg::POS_BITS-1:0]    pos_ff, pos_in;
   logic [1:0]                       face_ff, face_in;
   rsfh_pkg::div_ctl_type            div_ctl;
   logic [WW-1:0]                    div_dividend, div_divisor;
   logic                             div_done;
   logic [rsfh_pkg::QUOT_WIDTH-1:0]  div_quot;
   logic                             req_take;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   // Present the held hit, or a clean miss
   always_comb begin
      rsp_data.hit           = found_ff;
      rsp_data.distance      = found_ff ? dist_ff : '0;
      rsp_data.wall_position = found_ff ? pos_ff : '0;
      rsp_data.hit_face      = found_ff ? face_ff : '0;
   end

   // Select the operand pair for the shared multiplier
   always_comb begin
      case (step_ff)
         STEP_WIDTH'(0): begin op_a = MW'(item_ff.normal_x); op_b = MW'(item_ff.ray_dir_x); end
         STEP_WIDTH'(1): begin op_a = MW'(item_ff.normal_y); op_b = MW'(item_ff.ray_dir_y); end
         STEP_WIDTH'(2): begin op_a = d2x_ff; op_b = vx_ff; end
         STEP_WIDTH'(3): begin op_a = d2y_ff; op_b = vy_ff; end
         STEP_WIDTH'(4): begin op_a = d2x_ff; op_b = wy_ff; end
         STEP_WIDTH'(5): begin op_a = d2y_ff; op_b = wx_ff; end
         STEP_WIDTH'(6): begin op_a = wx_ff; op_b = vx_ff; end
         STEP_WIDTH'(7): begin op_a = wy_ff; op_b = vy_ff; end
         default:        begin op_a = '0; op_b = '0; end
      endcase
      prod_in  = op_a * op_b;
      prod_ext = AW'(prod_ff);
   end

   // Sign and range tests on the exact products
   always_comb begin
      dneg     = den_ff[AW-1];
      aden     = dneg ? (AW'(0) - den_ff) : den_ff;
      acrs     = crs_ff[AW-1] ? (AW'(0) - crs_ff) : crs_ff;
      anum     = num_ff[AW-1] ? (AW'(0) - num_ff) : num_ff;
      behind   = (crs_ff != '0) && (crs_ff[AW-1] != dneg);
      short_of = (num_ff != '0) && (num_ff[AW-1] != dneg);
      beyond   = (anum > aden);
      is_hit   = dot_ff[AW-1] && (den_ff != '0) && !behind && !short_of && !beyond;
   end

   // Sequence capture, products, tests and the two divisions
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      step_in      = step_ff;
      d2x_in       = d2x_ff;
      d2y_in       = d2y_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      dot_in       = dot_ff;
      den_in       = den_ff;
      crs_in       = crs_ff;
      num_in       = num_ff;
      found_in     = found_ff;
      dist_in      = dist_ff;
      pos_in       = pos_ff;
      face_in      = face_ff;
      div_ctl      = '0;
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               item_in = req_data;
               if (found_ff) begin
                  state_in = req_data.last_segment ? S_DONE : S_IDLE;
               end else begin
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            d2x_in   = MW'(item_ff.seg_end_x) - MW'(item_ff.seg_start_x);
            d2y_in   = MW'(item_ff.seg_end_y) - MW'(item_ff.seg_start_y);
            wx_in    = MW'(item_ff.ray_origin_x) - MW'(item_ff.seg_start_x);
            wy_in    = MW'(item_ff.ray_origin_y) - MW'(item_ff.seg_start_y);
            vx_in    = MW'(0) - MW'(item_ff.ray_dir_y);
            vy_in    = MW'(item_ff.ray_dir_x);
            step_in  = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            case (step_ff)
               STEP_WIDTH'(1): dot_in = prod_ext;
               STEP_WIDTH'(2): dot_in = dot_ff + prod_ext;
               STEP_WIDTH'(3): den_in = prod_ext;
               STEP_WIDTH'(4): den_in = den_ff + prod_ext;
               STEP_WIDTH'(5): crs_in = prod_ext;
               STEP_WIDTH'(6): crs_in = crs_ff - prod_ext;
               STEP_WIDTH'(7): num_in = prod_ext;
               STEP_WIDTH'(8): num_in = num_ff + prod_ext;
               default: ;
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_WIDTH'(LAST_STEP)) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (is_hit) begin
               div_ctl.start    = 1'b1;
               div_ctl.last_bit = rsfh_pkg::CNT_WIDTH'(rsfh_pkg::QUOT_WIDTH - 1);
               div_dividend     = WW'(acrs) << rsfh_pkg::DIST_SHIFT;
               div_divisor      = WW'(aden) << rsfh_pkg::DIST_BITS;
               state_in         = S_DIST;
            end else begin
               state_in = item_ff.last_segment ? S_DONE : S_IDLE;
            end
         end
         S_DIST: begin
            if (div_done) begin
               dist_in = div_quot[rsfh_pkg::QUOT_WIDTH-1] ? '1
                         : div_quot[rsfh_pkg::DIST_BITS-1:0];
               div_ctl.start    = 1'b1;
               div_ctl.last_bit = rsfh_pkg::CNT_WIDTH'(rsfh_pkg::POS_BITS - 1);
               div_dividend     = WW'(anum) << rsfh_pkg::POS_FRAC;
               div_divisor      = WW'(aden) << rsfh_pkg::POS_FRAC;
               state_in         = S_POS;
            end
         end
         S_POS: begin
            if (div_done) begin
               pos_in   = div_quot[rsfh_pkg::POS_BITS-1:0];
               face_in  = item_ff.face_tag;
               found_in = 1'b1;
               state_in = item_ff.last_segment ? S_DONE : S_IDLE;
            end
         end
         S_DONE: begin
            if (!rsp_stall) begin
               found_in = 1'b0;
               dist_in  = '0;
               pos_in   = '0;
               face_in  = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         found_ff <= 1'b0;
         dist_ff  <= '0;
         pos_ff   <= '0;
         face_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
         dist_ff  <= dist_in;
         pos_ff   <= pos_in;
         face_ff  <= face_in;
         step_ff  <= step_in;
      end
      item_ff <= item_in;
      d2x_ff  <= d2x_in;
      d2y_ff  <= d2y_in;
      wx_ff   <= wx_in;
      wy_ff   <= wy_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      prod_ff <= prod_in;
      dot_ff  <= dot_in;
      den_ff  <= den_in;
      crs_ff  <= crs_in;
      num_ff  <= num_in;
   end

   rsfh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot)
   );

   // Results block new requests
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while result pending");

   // Divider finishes only while a division is awaited
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIST || state_ff == S_POS))
      else $error("divider done outside a division state");

   // Miss carries zero fields
   a_clean_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |->
         (rsp_data.distance == '0 && rsp_data.wall_position == '0
          && rsp_data.hit_face == '0))
      else $error("miss result with stale fields");

   // Wall position never exceeds one
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |->
         (rsp_data.wall_position <= rsfh_pkg::POS_BITS'(1 << rsfh_pkg::POS_FRAC)))
      else $error("wall position above one");

   // Multiply and test follow each other
   a_check_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> ($past(state_ff) == S_MUL))
      else $error("check state not entered from multiply");

endmodule

`default_nettype wire
